// File: hdl/assert_macros.svh
// Assertion macros used by the scheduler datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: hdl/edf_pkg.sv
// Types and constants of the EDF task scheduler.
package edf_pkg;
  localparam int MAX_TASKS_DEF = 64;
  localparam int TIME_BITS_DEF = 16;
  localparam int PROG_BITS     = 16;
  localparam int CFG_BITS      = 7;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    logic        action;
    logic [5:0]  task_slot;
    logic [15:0] release_time;
    logic [15:0] run_length;
    logic [15:0] deadline;
  } req_t;

  typedef struct packed {
    logic [15:0] tick_time;
    logic        idle;
    logic [5:0]  selected_task;
    logic        switched;
    logic        completed;
    logic [15:0] response_time;
    logic [15:0] turnaround_time;
    logic [15:0] wait_time;
    logic        all_done;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic issue;
    logic rd_sel;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic scan_last;
  } status_t;
endpackage

// File: hdl/edf_task_scheduler.sv
// Top level of the preemptive earliest-deadline-first task scheduler.
// A load request (action 0) writes a task slot. A tick request
// scans the slots in use one per cycle through the task table RAM, then reads
// the chosen task and updates it. The scan covers task_count slots, saturated
// at MAX_TASKS, and is skipped when no slot is in use. busy is high meanwhile.
// Each tick gives one result, shown on res for one cycle with done high; the
// receiver cannot stall and must take it then.
module edf_task_scheduler #(
  parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = edf_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  edf_pkg::req_t                req,
  input  logic                         cfg_we,
  input  logic [edf_pkg::CFG_BITS-1:0] cfg_wdata,
  output logic                         done,
  output edf_pkg::res_t                res
);
  import edf_pkg::*;

  cmd_t    cmd;
  status_t sts;

  edf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(req.action),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  edf_dp #(.MAX_TASKS(MAX_TASKS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(req), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .sts(sts), .done(done), .res(res)
  );
endmodule

// File: hdl/edf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module edf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/edf_ctrl.sv
// Scheduler controller: sequences load, scan, fetch and execute steps.
module edf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            action,
  input  edf_pkg::status_t sts,
  output edf_pkg::cmd_t   cmd,
  output logic            busy
);
  import edf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (action == ACT_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.tick   = 1'b1;
            state_next = sts.n_zero ? ST_FETCH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FETCH;
      ST_FETCH: begin
        cmd.rd_sel = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// File: hdl/edf_dp.sv
// Scheduler datapath: task tables, deadline scan and completion math.
`include "assert_macros.svh"
module edf_dp #(
  parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = edf_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  edf_pkg::cmd_t    cmd,
  input  edf_pkg::req_t    req,
  input  logic             cfg_we,
  input  logic [edf_pkg::CFG_BITS-1:0] cfg_wdata,
  output edf_pkg::status_t sts,
  output logic             done,
  output edf_pkg::res_t    res
);
  import edf_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TB    = TIME_BITS;
  localparam int TBL_W = TB + 32;
  localparam logic [TB-1:0] TMAX = '1;
  localparam logic [PROG_BITS-1:0] PMAX = '1;

  logic [CFG_BITS-1:0]  task_count;
  logic [CNT_W-1:0]     n_use;
  logic [TB-1:0]        cur_time;
  logic [MAX_TASKS-1:0] fin;
  logic [IDX_W-1:0]     idx, cmp_idx, sel_idx, last_idx;
  logic                 cmp_valid, sel_none, last_none;
  logic [15:0]          best_dl;
  logic [CNT_W-1:0]     unf_cnt;

  logic [TBL_W-1:0]     tbl_rd;
  logic [PROG_BITS-1:0] prog_rd;
  logic [TB-1:0]        resp_rd;
  logic [TB-1:0]        rd_rel;
  logic [15:0]          rd_len, rd_dl;

  logic                 load_ok;
  logic                 cand;
  logic [TB-1:0]        fin_t, turn, resp_new;
  logic [PROG_BITS-1:0] prog_new;
  logic                 comp;
  logic [31:0]          wait_v;

  always_comb begin
    if (32'(task_count) > MAX_TASKS) begin
      n_use = CNT_W'(MAX_TASKS);
    end else begin
      n_use = CNT_W'(task_count);
    end
  end

  assign sts.n_zero    = (n_use == '0);
  assign sts.scan_last = ((CNT_W'(idx) + CNT_W'(1)) == n_use);

  assign load_ok = cmd.load && (32'(req.task_slot) < MAX_TASKS);
  assign rd_rel  = tbl_rd[TBL_W-1:32];
  assign rd_len  = tbl_rd[31:16];
  assign rd_dl   = tbl_rd[15:0];

  edf_ram #(.WIDTH(TBL_W), .DEPTH(MAX_TASKS)) u_tbl (
    .clk(clk), .we(load_ok), .waddr(IDX_W'(req.task_slot)),
    .wdata({TB'(req.release_time), req.run_length, req.deadline}),
    .raddr(cmd.rd_sel ? sel_idx : idx), .rdata(tbl_rd)
  );

  edf_ram #(.WIDTH(PROG_BITS), .DEPTH(MAX_TASKS)) u_prog (
    .clk(clk), .we(load_ok || (cmd.exec && !sel_none)),
    .waddr(cmd.load ? IDX_W'(req.task_slot) : sel_idx),
    .wdata(cmd.load ? '0 : prog_new), .raddr(sel_idx), .rdata(prog_rd)
  );

  edf_ram #(.WIDTH(TB), .DEPTH(MAX_TASKS)) u_resp (
    .clk(clk), .we(cmd.exec && !sel_none && (prog_rd == '0)),
    .waddr(sel_idx), .wdata(resp_new), .raddr(sel_idx), .rdata(resp_rd)
  );

  assign cand = cmp_valid && !fin[cmp_idx] && (rd_rel <= cur_time);

  always_comb begin
    fin_t    = (cur_time == TMAX) ? cur_time : cur_time + TB'(1);
    resp_new = (prog_rd == '0) ? (cur_time - rd_rel) : resp_rd;
    prog_new = (prog_rd < PMAX) ? prog_rd + PROG_BITS'(1) : prog_rd;
    comp     = !sel_none && (prog_new >= rd_len);
    turn     = fin_t - rd_rel;
    wait_v   = (32'(turn) > 32'(rd_len)) ? (32'(turn) - 32'(rd_len)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      cur_time   <= '0;
      fin        <= '0;
      last_none  <= 1'b1;
      cmp_valid  <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        task_count <= cfg_wdata;
      end
      cmp_valid <= cmd.issue;
      done      <= cmd.exec;
      if (load_ok) begin
        fin[IDX_W'(req.task_slot)] <= 1'b0;
      end
      if (cmd.exec) begin
        cur_time  <= fin_t;
        last_none <= sel_none;
        if (comp) begin
          fin[sel_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= idx;
    if (cmd.tick) begin
      idx      <= '0;
      sel_none <= 1'b1;
      sel_idx  <= '0;
      unf_cnt  <= '0;
    end else begin
      if (cmd.issue) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmp_valid && !fin[cmp_idx]) begin
        unf_cnt <= unf_cnt + CNT_W'(1);
      end
      if (cand && (sel_none || best_dl > rd_dl)) begin
        sel_none <= 1'b0;
        sel_idx  <= cmp_idx;
        best_dl  <= rd_dl;
      end
    end
    if (cmd.exec) begin
      last_idx            <= sel_idx;
      res.tick_time       <= 16'(cur_time);
      res.idle            <= sel_none;
      res.selected_task   <= sel_none ? 6'd0 : 6'(sel_idx);
      res.switched        <= (sel_none != last_none) ||
                             (!sel_none && (sel_idx != last_idx));
      res.completed       <= comp;
      res.response_time   <= comp ? 16'(resp_new) : 16'd0;
      res.turnaround_time <= comp ? 16'(turn) : 16'd0;
      res.wait_time       <= comp ? wait_v[15:0] : 16'd0;
      res.all_done        <= (unf_cnt == '0) ||
                             ((unf_cnt == CNT_W'(1)) && comp);
    end
  end

  `ASSERT_PROP(a_done_after_exec, clk, rst, done |-> $past(cmd.exec))
  `ASSERT_NEVER(a_idle_completed, clk, rst, done && res.idle && res.completed)
  `ASSERT_PROP(a_issue_feeds_cmp, clk, rst, cmd.issue |=> cmp_valid)
  `ASSERT_NEVER(a_sel_beyond_use, clk, rst, cmd.exec && !sel_none &&
                (CNT_W'(sel_idx) >= n_use))
endmodule

// File: bench/tb.sv
// Testbench for the EDF task scheduler: queued requests, a predictor and a result check.
`timescale 1ns / 1ps
module tb;
  import edf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;
  logic done;
  res_t res;

  edf_task_scheduler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .res(res)
  );

  always #5 clk = ~clk;

  req_t pending_reqs[$];
  res_t expected_ticks[$];
  int idle_pct = 27;
  int errors = 0;
  logic [15:0] gen_time = 0;

  // predictor state
  logic [15:0] slot_rel[MAX_TASKS_DEF];
  logic [15:0] slot_len[MAX_TASKS_DEF];
  logic [15:0] slot_dl[MAX_TASKS_DEF];
  logic [15:0] slot_prog[MAX_TASKS_DEF];
  logic [15:0] slot_resp[MAX_TASKS_DEF];
  bit slot_fin[MAX_TASKS_DEF];
  logic [15:0] sched_time = 0;
  int prev_sel = MAX_TASKS_DEF;
  int slots_cfg = 0;

  function automatic void schedule_step(req_t r);
    int n;
    int sel;
    res_t o;
    logic [15:0] fin_t;
    logic [15:0] turn;
    if (r.action == ACT_LOAD) begin
      slot_rel[r.task_slot] = r.release_time;
      slot_len[r.task_slot] = r.run_length;
      slot_dl[r.task_slot] = r.deadline;
      slot_prog[r.task_slot] = 0;
      slot_fin[r.task_slot] = 0;
      return;
    end
    n = slots_cfg > MAX_TASKS_DEF ? MAX_TASKS_DEF : slots_cfg;
    sel = MAX_TASKS_DEF;
    o = '0;
    for (int i = 0; i < n; i++) begin
      if (slot_fin[i] || slot_rel[i] > sched_time) continue;
      if (sel == MAX_TASKS_DEF || slot_dl[sel] > slot_dl[i]) sel = i;
    end
    if (sel != MAX_TASKS_DEF) begin
      fin_t = (sched_time == 16'hFFFF) ? 16'hFFFF : sched_time + 16'd1;
      if (slot_prog[sel] == 0) slot_resp[sel] = sched_time - slot_rel[sel];
      if (slot_prog[sel] < 16'hFFFF) slot_prog[sel]++;
      if (slot_prog[sel] >= slot_len[sel]) begin
        turn = fin_t - slot_rel[sel];
        slot_fin[sel] = 1;
        o.completed = 1'b1;
        o.response_time = slot_resp[sel];
        o.turnaround_time = turn;
        o.wait_time = (turn > slot_len[sel]) ? turn - slot_len[sel] : 16'd0;
      end
    end
    o.all_done = 1'b1;
    for (int i = 0; i < n; i++) if (!slot_fin[i]) o.all_done = 1'b0;
    o.tick_time = sched_time;
    o.idle = (sel == MAX_TASKS_DEF);
    o.selected_task = (sel == MAX_TASKS_DEF) ? 6'd0 : sel[5:0];
    o.switched = (sel != prev_sel);
    prev_sel = sel;
    sched_time = (sched_time == 16'hFFFF) ? 16'hFFFF : sched_time + 16'd1;
    expected_ticks.push_back(o);
  endfunction

  // driver
  always @(posedge clk) begin
    logic take;
    logic next_start;
    req_t next_req;
    next_start = start;
    next_req = req;
    if (!rst) begin
      take = start && !busy;
      if (take) begin
        schedule_step(pending_reqs.pop_front());
        next_start = 1'b0;
      end
      if (!next_start && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        next_start = 1'b1;
        next_req = pending_reqs[0];
      end
    end
    start <= next_start;
    req <= next_req;
  end

  task automatic check_field(string name, int e, int a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (expected_ticks.size() == 0) begin
        $error("unexpected result, tick_time %0d", res.tick_time);
        errors++;
      end else begin
        e = expected_ticks.pop_front();
        check_field("tick_time", e.tick_time, res.tick_time);
        check_field("idle", e.idle, res.idle);
        check_field("selected_task", e.selected_task, res.selected_task);
        check_field("switched", e.switched, res.switched);
        check_field("completed", e.completed, res.completed);
        check_field("response_time", e.response_time, res.response_time);
        check_field("turnaround_time", e.turnaround_time, res.turnaround_time);
        check_field("wait_time", e.wait_time, res.wait_time);
        check_field("all_done", e.all_done, res.all_done);
      end
    end
  end

  task automatic push_load(int slot, logic [15:0] rel, logic [15:0] len, logic [15:0] dl);
    req_t r;
    r.action = ACT_LOAD;
    r.task_slot = slot[5:0];
    r.release_time = rel;
    r.run_length = len;
    r.deadline = dl;
    pending_reqs.push_back(r);
  endtask

  task automatic push_tick();
    req_t r;
    r.action = ACT_TICK;
    r.task_slot = $urandom;
    r.release_time = $urandom;
    r.run_length = $urandom;
    r.deadline = $urandom;
    pending_reqs.push_back(r);
    if (gen_time != 16'hFFFF) gen_time++;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || expected_ticks.size() > 0 || busy || start);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_count(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[CFG_BITS-1:0];
    @(posedge clk);
    slots_cfg = v;
    cfg_we <= 1'b0;
  endtask

  task automatic random_load();
    logic [15:0] rel;
    logic [15:0] len;
    rel = gen_time + $urandom_range(12);
    len = $urandom_range(1, 6);
    if ($urandom_range(9) == 0) rel = $urandom;
    if ($urandom_range(14) == 0) len = $urandom;
    push_load($urandom_range(63), rel, len, $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_count(0);
    push_tick();
    push_tick();
    for (int s = 0; s < 64; s++)
      push_load(s, $urandom_range(6), $urandom_range(1, 4), $urandom_range(200));
    push_load(0, 0, 0, 16'd0);
    push_load(1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_load(2, 0, 16'hFFFF, 16'hFFFF);
    push_load(3, 1, 2, 16'd5);
    push_load(4, 1, 2, 16'd5);
    write_count(6);
    repeat (12) push_tick();
    write_count(127);
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 27 : (ph == 1) ? 63 : 0;
      for (int k = 0; k < 90; k++) begin
        if ($urandom_range(99) < 30) random_load();
        else push_tick();
      end
      write_count(ph == 0 ? 64 : ph == 1 ? $urandom_range(1, 127) : 1);
    end
    for (int k = 0; k < 40; k++) begin
      if ($urandom_range(99) < 30) random_load();
      else push_tick();
    end
    write_count(0);
    repeat (4) push_tick();
    write_count(3);
    push_load(0, 16'hFFF0, 3, 16'd9);
    push_load(1, 16'hFFFE, 16'hFFFF, 16'd1);
    push_load(2, 16'hFFFF, 1, 16'd2);
    repeat (20) push_tick();
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
